@@ rtl/lfps_pkg.sv @@
// ----------------------------------------------------------------------------
// lfps_pkg
// Shared types, widths and codes for the LED flash pattern sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package lfps_pkg;

   // Pattern store geometry
   localparam int MAX_ENTRIES = 255;
   localparam int ENTRY_W     = $clog2(MAX_ENTRIES);

   // Field widths
   localparam int CMD_W   = 3;
   localparam int INDEX_W = 8;
   localparam int TIME_W  = 16;
   localparam int COUNT_W = 8;
   localparam int DUTY_W  = 8;
   localparam int STATE_W = 2;
   localparam int RSP_W   = DUTY_W + STATE_W;

   // Duty ceiling
   localparam logic [DUTY_W-1:0] DUTY_MAX = DUTY_W'(255);

   // Commands
   localparam logic [CMD_W-1:0] CMD_TICK  = 3'd0;
   localparam logic [CMD_W-1:0] CMD_WRITE = 3'd1;
   localparam logic [CMD_W-1:0] CMD_START = 3'd2;
   localparam logic [CMD_W-1:0] CMD_ON    = 3'd3;
   localparam logic [CMD_W-1:0] CMD_OFF   = 3'd4;

   // LED modes
   localparam logic [STATE_W-1:0] MODE_OFF   = 2'd0;
   localparam logic [STATE_W-1:0] MODE_ON    = 2'd1;
   localparam logic [STATE_W-1:0] MODE_FLASH = 2'd2;

   // Register indexes
   localparam logic REG_BRIGHTNESS  = 1'b0;
   localparam logic REG_ACTIVE_HIGH = 1'b1;

   // Store access from the sequencer core
   typedef struct packed {
      logic               wr_en;
      logic [ENTRY_W-1:0] wr_addr;
      logic [TIME_W-1:0]  wr_data;
      logic [ENTRY_W-1:0] rd_addr;
   } store_req_type;

endpackage

`default_nettype wire

@@ rtl/lfps_store.sv @@
// ----------------------------------------------------------------------------
// lfps_store
// Pattern duration memory: one write, one registered read, write-first.
// ----------------------------------------------------------------------------
`default_nettype none

module lfps_store (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire lfps_pkg::store_req_type req,
   output logic [lfps_pkg::TIME_W-1:0]  rd_data
);

   logic [lfps_pkg::TIME_W-1:0] mem [lfps_pkg::MAX_ENTRIES];
   logic [lfps_pkg::TIME_W-1:0] rd_raw_ff;
   logic [lfps_pkg::TIME_W-1:0] fwd_data_ff;
   logic                        fwd_ff;

   always_ff @(posedge clock) begin
      if (req.wr_en) begin
         mem[req.wr_addr] <= req.wr_data;
      end
      rd_raw_ff   <= mem[req.rd_addr];
      fwd_data_ff <= req.wr_data;
   end

   // same-address write wins over the old contents
   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_ff <= 1'b0;
      end else begin
         fwd_ff <= req.wr_en && (req.wr_addr == req.rd_addr);
      end
   end

   assign rd_data = fwd_ff ? fwd_data_ff : rd_raw_ff;

endmodule

`default_nettype wire

@@ rtl/lfps_core.sv @@
// ----------------------------------------------------------------------------
// lfps_core
// Sequencer state: mode, position, elapsed time, pattern length; duty out.
// ----------------------------------------------------------------------------
`default_nettype none

module lfps_core (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          accept,
   input  wire logic [lfps_pkg::CMD_W-1:0]    cmd,
   input  wire logic [lfps_pkg::INDEX_W-1:0]  entry_index,
   input  wire logic [lfps_pkg::TIME_W-1:0]   duration_ms,
   input  wire logic [lfps_pkg::COUNT_W-1:0]  pattern_count,
   input  wire logic [lfps_pkg::DUTY_W-1:0]   brightness,
   input  wire logic                          active_high,
   input  wire logic [lfps_pkg::TIME_W-1:0]   cur_dur,
   output lfps_pkg::store_req_type            store_req,
   output logic [lfps_pkg::DUTY_W-1:0]        duty,
   output logic [lfps_pkg::STATE_W-1:0]       lamp_state
);

   logic [lfps_pkg::STATE_W-1:0] mode_ff, mode_in;
   logic [lfps_pkg::ENTRY_W-1:0] position_ff, position_in;
   logic [lfps_pkg::TIME_W-1:0]  elapsed_ff, elapsed_in;
   logic [lfps_pkg::COUNT_W-1:0] len_ff, len_in;

   logic [lfps_pkg::TIME_W-1:0]  limit;
   logic [lfps_pkg::TIME_W-1:0]  elapsed_inc;
   logic [lfps_pkg::COUNT_W:0]   pos_inc;
   logic                         lit;
   logic [lfps_pkg::DUTY_W-1:0]  bright_clamp;
   logic [lfps_pkg::DUTY_W-1:0]  level;

   always_comb begin
      mode_in     = mode_ff;
      position_in = position_ff;
      elapsed_in  = elapsed_ff;
      len_in      = len_ff;
      store_req.wr_en   = 1'b0;
      store_req.wr_addr = entry_index[lfps_pkg::ENTRY_W-1:0];
      store_req.wr_data = duration_ms;

      // zero duration still holds for one tick
      limit       = (cur_dur == '0) ? lfps_pkg::TIME_W'(1) : cur_dur;
      elapsed_inc = elapsed_ff + lfps_pkg::TIME_W'(1);
      pos_inc     = (lfps_pkg::COUNT_W+1)'(position_ff) + (lfps_pkg::COUNT_W+1)'(1);

      if (accept) begin
         case (cmd)
            lfps_pkg::CMD_TICK: begin
               if (mode_ff == lfps_pkg::MODE_FLASH) begin
                  if (elapsed_inc >= limit) begin
                     elapsed_in = '0;
                     if (pos_inc >= {1'b0, len_ff}) begin
                        position_in = '0;
                     end else begin
                        position_in = pos_inc[lfps_pkg::ENTRY_W-1:0];
                     end
                  end else begin
                     elapsed_in = elapsed_inc;
                  end
               end
            end
            lfps_pkg::CMD_WRITE: begin
               store_req.wr_en = (32'(entry_index) < lfps_pkg::MAX_ENTRIES);
            end
            lfps_pkg::CMD_START: begin
               position_in = '0;
               elapsed_in  = '0;
               if (pattern_count == '0) begin
                  len_in  = '0;
                  mode_in = lfps_pkg::MODE_OFF;
               end else begin
                  len_in  = (32'(pattern_count) > lfps_pkg::MAX_ENTRIES)
                          ? lfps_pkg::COUNT_W'(lfps_pkg::MAX_ENTRIES) : pattern_count;
                  mode_in = lfps_pkg::MODE_FLASH;
               end
            end
            lfps_pkg::CMD_ON: begin
               mode_in     = lfps_pkg::MODE_ON;
               position_in = '0;
               elapsed_in  = '0;
            end
            lfps_pkg::CMD_OFF: begin
               mode_in     = lfps_pkg::MODE_OFF;
               position_in = '0;
               elapsed_in  = '0;
            end
            default: begin
            end
         endcase
      end

      // prefetch the duration of the entry shown next cycle
      store_req.rd_addr = position_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= lfps_pkg::MODE_OFF;
         position_ff <= '0;
         elapsed_ff  <= '0;
         len_ff      <= '0;
      end else begin
         mode_ff     <= mode_in;
         position_ff <= position_in;
         elapsed_ff  <= elapsed_in;
         len_ff      <= len_in;
      end
   end

   // output from the updated state
   always_comb begin
      lit = (mode_in == lfps_pkg::MODE_ON) ||
            ((mode_in == lfps_pkg::MODE_FLASH) && !position_in[0]);
      bright_clamp = (brightness > lfps_pkg::DUTY_MAX) ? lfps_pkg::DUTY_MAX : brightness;
      level        = lit ? bright_clamp : '0;
      duty         = active_high ? level : (lfps_pkg::DUTY_MAX - level);
      lamp_state   = mode_in;
   end

   a_flash_len: assert property (@(posedge clock) disable iff (reset)
      (mode_ff == lfps_pkg::MODE_FLASH) |-> (len_ff != '0))
      else $error("flashing with empty pattern");

   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      (mode_ff == lfps_pkg::MODE_FLASH) |-> ({1'b0, position_ff} < {1'b0, len_ff}))
      else $error("position beyond pattern length");

   a_off_clears: assert property (@(posedge clock) disable iff (reset)
      (accept && (cmd == lfps_pkg::CMD_OFF)) |=>
      ((mode_ff == lfps_pkg::MODE_OFF) && (position_ff == '0) && (elapsed_ff == '0)))
      else $error("off command did not restart sequencer");

endmodule

`default_nettype wire

@@ rtl/lfps_skid.sv @@
// ----------------------------------------------------------------------------
// lfps_skid
// Result register with a skid stage; ready is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module lfps_skid (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       in_valid,
   output logic                            in_ready,
   input  wire logic [lfps_pkg::RSP_W-1:0] in_data,
   output logic                            out_valid,
   input  wire logic                       out_ready,
   output logic [lfps_pkg::RSP_W-1:0]      out_data
);

   logic                       out_valid_ff;
   logic [lfps_pkg::RSP_W-1:0] out_data_ff;
   logic                       skid_valid_ff;
   logic [lfps_pkg::RSP_W-1:0] skid_data_ff;
   logic                       load_out;

   assign in_ready = !skid_valid_ff;
   assign load_out = out_ready || !out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (load_out) begin
         out_valid_ff  <= skid_valid_ff || in_valid;
         skid_valid_ff <= 1'b0;
      end else if (in_valid && in_ready) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         out_data_ff <= skid_valid_ff ? skid_data_ff : in_data;
      end else if (in_valid && in_ready) begin
         skid_data_ff <= in_data;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid holds an item ahead of the result register");

endmodule

`default_nettype wire

@@ rtl/led_flash_pattern_sequencer.sv @@
// Results are registered: an accepted item's result goes to the result register, or to the skid while rsp_ is stalled.
// Throughput: one item per cycle while req_tready is high; state update and duty are single-pass logic
//   behind the pattern store's registered read.
// Result register plus skid hold two results; req_tready drops only when both are full.
// Reset: synchronous; mode off, position, elapsed time and length cleared,
//   brightness 255, active high; pattern store contents undefined until written.
// ----------------------------------------------------------------------------
// led_flash_pattern_sequencer
// Tick-driven LED blink pattern engine with PWM duty and LED state output.
// ----------------------------------------------------------------------------
`default_nettype none

module led_flash_pattern_sequencer (
   input  wire logic        clock,
   input  wire logic        reset,
   // request stream
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,   // entry_index[7:0], duration_ms[23:8], pattern_count[31:24]
   input  wire logic [2:0]  req_tuser,   // cmd[2:0]
   // result stream
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata,   // duty[7:0], lamp_state[9:8], zero[15:10]
   // register writes
   input  wire logic        csr_we,
   input  wire logic        csr_addr,
   input  wire logic [7:0]  csr_wdata
);

   // Config registers
   logic [lfps_pkg::DUTY_W-1:0] brightness_ff;
   logic                        active_high_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         brightness_ff  <= lfps_pkg::DUTY_W'(255);
         active_high_ff <= 1'b1;
      end else if (csr_we) begin
         case (csr_addr)
            lfps_pkg::REG_BRIGHTNESS:  brightness_ff  <= csr_wdata;
            lfps_pkg::REG_ACTIVE_HIGH: active_high_ff <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   // Item accepted when the result stage has room
   logic                          accept;
   logic                          stage_ready;
   lfps_pkg::store_req_type       store_req;
   logic [lfps_pkg::TIME_W-1:0]   cur_dur;
   logic [lfps_pkg::DUTY_W-1:0]   duty;
   logic [lfps_pkg::STATE_W-1:0]  lamp_state;
   logic [lfps_pkg::RSP_W-1:0]    rsp_payload;

   assign req_tready = stage_ready;
   assign accept     = req_tvalid && stage_ready;

   // Duration of the entry now on display, prefetched through the store's registered read
   lfps_store u_store (
      .clock   (clock),
      .reset   (reset),
      .req     (store_req),
      .rd_data (cur_dur)
   );

   lfps_core u_core (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .cmd           (req_tuser),
      .entry_index   (req_tdata[7:0]),
      .duration_ms   (req_tdata[23:8]),
      .pattern_count (req_tdata[31:24]),
      .brightness    (brightness_ff),
      .active_high   (active_high_ff),
      .cur_dur       (cur_dur),
      .store_req     (store_req),
      .duty          (duty),
      .lamp_state    (lamp_state)
   );

   assign rsp_payload = {lamp_state, duty};

   // Result register and skid
   logic [lfps_pkg::RSP_W-1:0] rsp_data;

   lfps_skid u_skid (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .in_ready  (stage_ready),
      .in_data   (rsp_payload),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (rsp_data)
   );

   assign rsp_tdata = {{(16 - lfps_pkg::RSP_W){1'b0}}, rsp_data};

endmodule

`default_nettype wire
